### hdl/adaptive_scalar_kalman_filter_top_defines.svh
// Assertion macros for the adaptive scalar Kalman filter checker.
`ifndef ADAPTIVE_SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define ADAPTIVE_SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

// Antecedent holds now, consequent holds in the next cycle.
`define ASKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("askf assertion failed: next-cycle check");

// Antecedent and consequent hold in the same cycle.
`define ASKF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("askf assertion failed: same-cycle check");

`endif

### hdl/askf_pkg.sv
// ----------------------------------------------------------------------------
// askf_pkg
// Shared constants, types and register map of the adaptive Kalman filter.
// ----------------------------------------------------------------------------
package askf_pkg;

    localparam int WIN_DEPTH = 16;                 // power of two
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = SAMPLE_W + WIN_AW;
    localparam int SUMSQ_W   = 2 * SAMPLE_W + WIN_AW;
    localparam int SCALE_SH  = 16 - 2 * WIN_AW;    // 65536 / (N*N)
    localparam int EST_W     = 40;
    localparam int DIFF_W    = EST_W + 1;
    localparam int K_W       = 25;
    localparam int DEN_W     = 54;
    localparam int LO_W      = 21;
    localparam int HI_W      = DIFF_W - LO_W;

    localparam logic [31:0] COV_RESET  = 32'h0100_0000;
    localparam logic [15:0] PNOISE_RST = 16'd983;
    localparam logic [31:0] NBASE_RST  = 32'd256;
    localparam logic [11:0] DGAIN_RST  = 12'd640;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_PROC_NOISE = 2'd0;
    localparam logic [1:0] REG_NOISE_BASE = 2'd1;
    localparam logic [1:0] REG_DEV_GAIN   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_SQ,
        ST_M,
        ST_SQRT,
        ST_RCALC,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                       we;
        logic [WIN_AW-1:0]          waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [WIN_AW-1:0]          raddr;
    } win_req_t;

endpackage

### hdl/askf_if.sv
// ----------------------------------------------------------------------------
// askf_in_if / askf_out_if
// Valid/ready channels for samples and filter results.
// ----------------------------------------------------------------------------
interface askf_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface askf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] estimate;
    logic [31:0]        noise_std;
    modport source (output valid, output estimate, output noise_std, input ready);
    modport sink (input valid, input estimate, input noise_std, output ready);
endinterface

### hdl/askf_win_mem.sv
// ----------------------------------------------------------------------------
// askf_win_mem
// Sample window memory, registered read, per-entry valid bits.
// ----------------------------------------------------------------------------
module askf_win_mem (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  askf_pkg::win_req_t                           req,
    output logic signed [askf_pkg::SAMPLE_W-1:0]         rdata
);
    import askf_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [WIN_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [WIN_DEPTH-1:0]       valid_reg;
    logic                       rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

### hdl/askf_isqrt.sv
// ----------------------------------------------------------------------------
// askf_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module askf_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);
    import askf_pkg::*;

    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = value;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

### hdl/askf_div.sv
// ----------------------------------------------------------------------------
// askf_div
// Restoring divider for the Kalman gain: floor(p * 2^24 / den).
// ----------------------------------------------------------------------------
module askf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   p,
    input  logic [askf_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [askf_pkg::K_W-1:0]      quot
);
    import askf_pkg::*;

    localparam int SH_W = DEN_W + K_W - 1;

    logic [SH_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0] dsh_reg, dsh_next;
    logic [K_W-1:0]  q_reg, q_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            zero_reg, zero_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {{(SH_W-56){1'b0}}, p, 24'd0};
            dsh_next  = {den, {(K_W-1){1'b0}}};
            q_next    = '0;
            cnt_next  = 5'(K_W - 1);
            busy_next = 1'b1;
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            q_next = q_reg << 1;
            if (rem_reg >= dsh_reg)
            begin
                rem_next  = rem_reg - dsh_reg;
                q_next[0] = 1'b1;
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

### hdl/adaptive_scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// adaptive_scalar_kalman_filter_top
// Adaptive scalar Kalman filter over a 16-entry sample window.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one signed 24-bit sample per request; output
// channel out_ch returns one result per sample: estimate (Q24.8) and
// noise_std (window deviation, Q24.8). Both use valid/ready.
// An APB port sets process_noise (0x0), noise_floor_base (0x4) and
// deviation_gain (0x8); pready is tied high, other addresses are ignored.
// Each sample passes from accept to output valid through a walk over the
// window memory (one read port), the sums, the bit-serial square root, r,
// the gain divider and the update and output steps. One sample is processed
// at a time and the next is accepted in the idle state that follows.
// A finished result sits in the output register; the next sample is taken
// while it waits. If the receiver stalls, the following result holds in the
// last step until the output register frees.
// Reset clears the window (valid bits), estimate, covariance (1.0) and
// registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adaptive_scalar_kalman_filter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    askf_in_if.sink                       in_ch,
    askf_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [askf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import askf_pkg::*;

    state_t state_reg, state_next;

    logic [15:0] pnoise_reg;
    logic [31:0] nbase_reg;
    logic [11:0] dgain_reg;

    logic [WIN_AW-1:0]          wpos_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic signed [EST_W-1:0]    est_reg, est_next;
    logic [31:0]                cov_reg, cov_next;

    logic [WIN_AW:0]             cnt_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [SUMSQ_W-1:0]          sumsq_reg;
    logic [2*SUM_W-1:0]          ssq_reg;
    logic [31:0]                 dev_reg;
    logic [31:0]                 p_reg;
    logic [DIFF_W-1:0]           mag_reg;
    logic                        neg_reg;
    logic [K_W-1:0]              k_reg;
    logic [K_W+LO_W-1:0]         prod0_reg;
    logic [K_W+HI_W-1:0]         prod1_reg;
    logic [K_W+31:0]             covp_reg;

    logic                        out_valid_reg;
    logic signed [31:0]          out_est_reg;
    logic [31:0]                 out_std_reg;

    win_req_t                    win_req;
    logic signed [SAMPLE_W-1:0]  win_rdata;

    logic                        in_acc;
    logic                        out_free;
    logic                        cfg_wr;
    logic                        sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]                 sqrt_root;
    logic [K_W-1:0]              div_q;

    logic [SUM_W-1:0]            sum_mag;
    logic [63:0]                 m_val, scaled;
    logic [43:0]                 dev_gain;
    logic [36:0]                 r_val;
    logic [32:0]                 p_sum;
    logic [31:0]                 p_sat;
    logic [DEN_W-1:0]            den;
    logic signed [DIFF_W-1:0]    diff;
    logic [K_W+DIFF_W:0]         prod_sum;
    logic [DIFF_W-1:0]           corr;
    logic [K_W-1:0]              one_minus_k;
    logic signed [2*SAMPLE_W-1:0] sq;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // configuration
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PROC_NOISE: prdata = {16'd0, pnoise_reg};
            REG_NOISE_BASE: prdata = nbase_reg;
            REG_DEV_GAIN:   prdata = {20'd0, dgain_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnoise_reg <= PNOISE_RST;
            nbase_reg  <= NBASE_RST;
            dgain_reg  <= DGAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PROC_NOISE: pnoise_reg <= pwdata[15:0];
                REG_NOISE_BASE: nbase_reg  <= pwdata;
                REG_DEV_GAIN:   dgain_reg  <= pwdata[11:0];
                default:        ;
            endcase
        end
    end

    // window memory
    always_comb
    begin
        win_req.we    = in_acc;
        win_req.waddr = wpos_reg;
        win_req.wdata = in_ch.sample;
        win_req.raddr = cnt_reg[WIN_AW-1:0];
    end

    askf_win_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (win_req),
        .rdata (win_rdata)
    );

    assign sqrt_start = (state_reg == ST_M);
    assign div_start  = (state_reg == ST_RCALC);

    askf_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (scaled),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    askf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .p     (p_sat),
        .den   (den),
        .done  (div_done),
        .quot  (div_q)
    );

    // datapath
    assign sq      = win_rdata * win_rdata;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign m_val   = (64'(sumsq_reg) << WIN_AW) - 64'(ssq_reg);
    assign scaled  = m_val << SCALE_SH;

    assign dev_gain = 44'(dev_reg) * 44'(dgain_reg);
    assign r_val    = 37'(nbase_reg) + 37'(dev_gain[43:8]);
    assign p_sum    = 33'(cov_reg) + {9'd0, pnoise_reg, 8'd0};
    assign p_sat    = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    assign den      = DEN_W'(p_sat) + {r_val, 16'd0};

    assign diff        = ($signed(DIFF_W'(s_reg)) <<< 16) - DIFF_W'(est_reg);
    assign prod_sum    = (K_W+DIFF_W+1)'(prod0_reg)
                       + ((K_W+DIFF_W+1)'(prod1_reg) << LO_W);
    assign corr        = prod_sum[K_W+DIFF_W-2:24];
    assign one_minus_k = K_W'(25'h100_0000) - k_reg;

    always_comb
    begin
        est_next = est_reg;
        cov_next = cov_reg;
        if (state_reg == ST_UPD)
        begin
            est_next = neg_reg ? est_reg - EST_W'(corr) : est_reg + EST_W'(corr);
            cov_next = covp_reg[55:24];
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_WALK;
            ST_WALK:  if (cnt_reg == (WIN_AW+1)'(WIN_DEPTH)) state_next = ST_SQ;
            ST_SQ:    state_next = ST_M;
            ST_M:     state_next = ST_SQRT;
            ST_SQRT:  if (sqrt_done) state_next = ST_RCALC;
            ST_RCALC: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wpos_reg      <= '0;
            est_reg       <= '0;
            cov_reg       <= COV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            est_reg   <= est_next;
            cov_reg   <= cov_next;
            if (in_acc)
            begin
                wpos_reg <= wpos_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s_reg     <= in_ch.sample;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        if (state_reg == ST_WALK)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg != '0)
            begin
                sum_reg   <= sum_reg + SUM_W'(win_rdata);
                sumsq_reg <= sumsq_reg + SUMSQ_W'($unsigned(sq));
            end
        end
        if (state_reg == ST_SQ)
        begin
            ssq_reg <= (2*SUM_W)'(sum_mag) * (2*SUM_W)'(sum_mag);
        end
        if (state_reg == ST_SQRT && sqrt_done)
        begin
            dev_reg <= sqrt_root;
        end
        if (state_reg == ST_RCALC)
        begin
            p_reg   <= p_sat;
            neg_reg <= diff[DIFF_W-1];
            mag_reg <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        end
        if (state_reg == ST_DIV && div_done)
        begin
            k_reg <= div_q;
        end
        if (state_reg == ST_MUL)
        begin
            prod0_reg <= (K_W+LO_W)'(k_reg) * (K_W+LO_W)'(mag_reg[LO_W-1:0]);
            prod1_reg <= (K_W+HI_W)'(k_reg) * (K_W+HI_W)'(mag_reg[DIFF_W-1:LO_W]);
            covp_reg  <= (K_W+32)'(one_minus_k) * (K_W+32)'(p_reg);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_est_reg <= est_reg[EST_W-1:8];
            out_std_reg <= dev_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.estimate  = out_est_reg;
    assign out_ch.noise_std = out_std_reg;

endmodule

### hdl/askf_checker.sv
// ----------------------------------------------------------------------------
// askf_checker
// Port-level checks on the adaptive Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_scalar_kalman_filter_top_defines.svh"

module askf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_estimate,
    input logic        pready
);

    `ASKF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASKF_ASSERT_NEXT(a_est_hold, out_valid && !out_ready, $stable(out_estimate))
    `ASKF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    `ASKF_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind adaptive_scalar_kalman_filter_top askf_checker u_askf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_estimate (out_ch.estimate),
    .pready       (pready)
);
